@@ design/crt_pkg.sv @@
// ----------------------------------------------------------------------------
// crt_pkg
// Shared constants, result codes and controller/datapath structs of the
// csv record tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package crt_pkg;

   localparam int MAX_COLUMNS = 32;
   localparam int COL_LIMIT   = 62;
   localparam int BYTE_W      = 8;
   localparam int COL_W       = 6;
   localparam int KIND_W      = 2;
   localparam int OP_W        = 2;

   // largest usable column count
   localparam logic [COL_W-1:0] COL_CAP =
      COL_W'((MAX_COLUMNS < COL_LIMIT) ? MAX_COLUMNS : COL_LIMIT);

   // register index of column_count, taken from word address bit 2
   localparam logic REG_COLUMN_COUNT = 1'b0;

   localparam logic [BYTE_W-1:0] CHAR_QUOTE = 8'h22;
   localparam logic [BYTE_W-1:0] CHAR_COMMA = 8'h2C;
   localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;
   localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;

   localparam logic [KIND_W-1:0] KIND_CONTENT   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_FIELD_END = 2'd1;
   localparam logic [KIND_W-1:0] KIND_ROW_END   = 2'd2;

   // datapath step codes
   localparam logic [OP_W-1:0] OP_NONE    = 2'd0;
   localparam logic [OP_W-1:0] OP_FIELD   = 2'd1;
   localparam logic [OP_W-1:0] OP_CONTENT = 2'd2;
   localparam logic [OP_W-1:0] OP_ROW     = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            last;
      logic            load;
   } cmd_type;

   typedef struct packed {
      logic slot_free;
      logic col_lt_n;
      logic col_inc_lt_n;
   } status_type;

endpackage

`default_nettype wire

@@ design/crt_if.sv @@
// ----------------------------------------------------------------------------
// crt_if
// Valid/ready channels of the csv record tokenizer: byte input and result
// output.
// ----------------------------------------------------------------------------
`default_nettype none

interface crt_req_if;
   import crt_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] text_byte;
   logic              final_byte;

   modport source (output valid, output text_byte, output final_byte, input ready);
   modport sink (input valid, input text_byte, input final_byte, output ready);
endinterface

interface crt_rsp_if;
   import crt_pkg::*;

   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   logic [BYTE_W-1:0] content;
   logic [COL_W-1:0]  column;
   logic              run_last;

   modport source (output valid, output kind, output content, output column,
                   output run_last, input ready);
   modport sink (input valid, input kind, input content, input column,
                 input run_last, output ready);
endinterface

`default_nettype wire

@@ design/crt_ctrl.sv @@
// ----------------------------------------------------------------------------
// crt_ctrl
// Lexer state and step sequencer: decodes each byte into a plan of field,
// content and row steps, issued one per cycle to the datapath when slot_free.
// ----------------------------------------------------------------------------
`default_nettype none

module crt_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic [crt_pkg::BYTE_W-1:0] req_text_byte,
   input  logic                       req_final_byte,
   output logic                       req_ready,
   input  crt_pkg::status_type        status,
   output crt_pkg::cmd_type           cmd
);
   import crt_pkg::*;

   localparam logic [1:0] S_IDLE    = 2'd0;
   localparam logic [1:0] S_FIELD   = 2'd1;
   localparam logic [1:0] S_CONTENT = 2'd2;
   localparam logic [1:0] S_ROW     = 2'd3;

   localparam logic [1:0] MODE_START  = 2'd0;
   localparam logic [1:0] MODE_PLAIN  = 2'd1;
   localparam logic [1:0] MODE_QUOTED = 2'd2;
   localparam logic [1:0] MODE_AFTERQ = 2'd3;

   logic [1:0] state_ff, state_in;
   logic [1:0] mode_ff, mode_in;
   logic       cr_ff, cr_in;
   logic       row_open_ff, row_open_in;
   logic       content_ff, content_in;
   logic       row_ff, row_in;

   logic       final_step;
   logic       accept;
   logic       is_quote, is_comma, is_brk;
   logic       do_field, do_content, do_row;
   logic [1:0] dec_mode;
   logic       dec_cr, dec_row_open;
   logic [1:0] after_step;

   // byte decode against current lexer state
   always_comb begin
      is_quote     = (req_text_byte == CHAR_QUOTE);
      is_comma     = (req_text_byte == CHAR_COMMA);
      is_brk       = (req_text_byte == CHAR_CR) || (req_text_byte == CHAR_LF);
      do_field     = 1'b0;
      do_content   = 1'b0;
      do_row       = 1'b0;
      dec_mode     = mode_ff;
      dec_cr       = 1'b0;
      dec_row_open = row_open_ff;
      if (!(cr_ff && (req_text_byte == CHAR_LF))) begin
         dec_row_open = 1'b1;
         case (mode_ff)
            MODE_START: begin
               if (is_quote) begin
                  dec_mode = MODE_QUOTED;
               end else if (is_comma) begin
                  do_field = 1'b1;
               end else if (is_brk) begin
                  do_row = 1'b1;
               end else begin
                  do_content = 1'b1;
                  dec_mode   = MODE_PLAIN;
               end
            end
            MODE_PLAIN: begin
               if (is_comma) begin
                  do_field = 1'b1;
                  dec_mode = MODE_START;
               end else if (is_brk) begin
                  do_row = 1'b1;
               end else begin
                  do_content = 1'b1;
               end
            end
            MODE_QUOTED: begin
               if (is_quote) begin
                  dec_mode = MODE_AFTERQ;
               end else begin
                  do_content = 1'b1;
               end
            end
            default: begin
               if (is_quote) begin
                  do_content = 1'b1;
                  dec_mode   = MODE_QUOTED;
               end else if (is_comma) begin
                  do_field = 1'b1;
                  dec_mode = MODE_START;
               end else if (is_brk) begin
                  do_row = 1'b1;
               end else begin
                  do_field   = 1'b1;
                  do_content = 1'b1;
                  dec_mode   = MODE_PLAIN;
               end
            end
         endcase
         if (do_row) begin
            dec_cr       = (req_text_byte == CHAR_CR);
            dec_mode     = MODE_START;
            dec_row_open = 1'b0;
         end
      end
      // end of input closes an open row and clears the lexer
      if (req_final_byte) begin
         if (dec_row_open) begin
            do_row = 1'b1;
         end
         dec_mode     = MODE_START;
         dec_cr       = 1'b0;
         dec_row_open = 1'b0;
      end
   end

   always_comb begin
      case (state_ff)
         S_IDLE:    final_step = 1'b1;
         S_FIELD:   final_step = !content_ff && !row_ff;
         S_CONTENT: final_step = !row_ff;
         S_ROW:     final_step = !status.col_lt_n;
         default:   final_step = 1'b1;
      endcase
   end

   assign req_ready = (state_ff == S_IDLE) || (status.slot_free && final_step);
   assign accept    = req_valid && req_ready;

   always_comb begin
      cmd.op   = OP_NONE;
      cmd.last = 1'b0;
      cmd.load = accept;
      if (status.slot_free) begin
         case (state_ff)
            S_FIELD: begin
               cmd.op   = OP_FIELD;
               cmd.last = !row_ff && !(content_ff && status.col_inc_lt_n);
            end
            S_CONTENT: begin
               cmd.op   = OP_CONTENT;
               cmd.last = !row_ff;
            end
            S_ROW: begin
               cmd.op   = OP_ROW;
               cmd.last = !status.col_lt_n;
            end
            default: begin
               cmd.op   = OP_NONE;
               cmd.last = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      case (state_ff)
         S_FIELD:   after_step = content_ff ? S_CONTENT : (row_ff ? S_ROW : S_IDLE);
         S_CONTENT: after_step = row_ff ? S_ROW : S_IDLE;
         S_ROW:     after_step = status.col_lt_n ? S_ROW : S_IDLE;
         default:   after_step = S_IDLE;
      endcase
   end

   always_comb begin
      state_in    = state_ff;
      mode_in     = mode_ff;
      cr_in       = cr_ff;
      row_open_in = row_open_ff;
      content_in  = content_ff;
      row_in      = row_ff;
      if (state_ff != S_IDLE && status.slot_free) begin
         state_in = after_step;
      end
      if (accept) begin
         mode_in     = dec_mode;
         cr_in       = dec_cr;
         row_open_in = dec_row_open;
         content_in  = do_content;
         row_in      = do_row;
         if (do_field) begin
            state_in = S_FIELD;
         end else if (do_content) begin
            state_in = S_CONTENT;
         end else if (do_row) begin
            state_in = S_ROW;
         end else begin
            state_in = S_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         mode_ff     <= MODE_START;
         cr_ff       <= 1'b0;
         row_open_ff <= 1'b0;
         content_ff  <= 1'b0;
         row_ff      <= 1'b0;
      end else begin
         state_ff    <= state_in;
         mode_ff     <= mode_in;
         cr_ff       <= cr_in;
         row_open_ff <= row_open_in;
         content_ff  <= content_in;
         row_ff      <= row_in;
      end
   end

endmodule

`default_nettype wire

@@ design/crt_datapath.sv @@
// ----------------------------------------------------------------------------
// crt_datapath
// Column counter, effective column limit, held byte and the result output
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module crt_datapath (
   input  logic                       clock,
   input  logic                       reset,
   input  crt_pkg::cmd_type           cmd,
   input  logic [crt_pkg::BYTE_W-1:0] req_text_byte,
   input  logic [crt_pkg::COL_W-1:0]  column_count,
   output crt_pkg::status_type        status,
   input  logic                       rsp_ready,
   output logic                       rsp_valid,
   output logic [crt_pkg::KIND_W-1:0] rsp_kind,
   output logic [crt_pkg::BYTE_W-1:0] rsp_content,
   output logic [crt_pkg::COL_W-1:0]  rsp_column,
   output logic                       rsp_run_last
);
   import crt_pkg::*;

   logic [COL_W-1:0]  column_ff, column_in;
   logic [BYTE_W-1:0] byte_ff;
   logic              valid_ff, valid_in;
   logic [KIND_W-1:0] kind_ff, kind_in;
   logic [BYTE_W-1:0] content_ff, content_in;
   logic [COL_W-1:0]  col_out_ff, col_out_in;
   logic              last_ff, last_in;
   logic              emit;
   logic [COL_W-1:0]  eff;
   logic [COL_W-1:0]  column_sat;

   // effective column count: at least one, at most the cap
   always_comb begin
      eff = column_count;
      if (eff == '0) begin
         eff = COL_W'(1);
      end
      if (eff > COL_CAP) begin
         eff = COL_CAP;
      end
   end

   assign status.col_lt_n     = (column_ff < eff);
   assign status.col_inc_lt_n = ({1'b0, column_ff} + 7'd1) < {1'b0, eff};
   assign status.slot_free    = !valid_ff || rsp_ready;

   assign column_sat = (column_ff == '1) ? column_ff : column_ff + COL_W'(1);

   always_comb begin
      emit       = 1'b0;
      kind_in    = KIND_FIELD_END;
      content_in = '0;
      col_out_in = column_ff;
      last_in    = cmd.last;
      column_in  = column_ff;
      case (cmd.op)
         OP_FIELD: begin
            emit      = status.col_lt_n;
            column_in = column_sat;
         end
         OP_CONTENT: begin
            emit       = status.col_lt_n;
            kind_in    = KIND_CONTENT;
            content_in = byte_ff;
         end
         OP_ROW: begin
            emit = 1'b1;
            if (status.col_lt_n) begin
               column_in = column_sat;
            end else begin
               kind_in    = KIND_ROW_END;
               col_out_in = '0;
               column_in  = '0;
            end
         end
         default: begin
            emit = 1'b0;
         end
      endcase
      valid_in = emit || (valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= '0;
         valid_ff  <= 1'b0;
      end else begin
         column_ff <= column_in;
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         byte_ff <= req_text_byte;
      end
      if (emit) begin
         kind_ff    <= kind_in;
         content_ff <= content_in;
         col_out_ff <= col_out_in;
         last_ff    <= last_in;
      end
   end

   assign rsp_valid    = valid_ff;
   assign rsp_kind     = kind_ff;
   assign rsp_content  = content_ff;
   assign rsp_column   = col_out_ff;
   assign rsp_run_last = last_ff;

endmodule

`default_nettype wire

@@ design/csv_record_tokenizer.sv @@
// ----------------------------------------------------------------------------
// csv_record_tokenizer
// Streaming csv splitter: one text byte per transfer in, a run of content,
// field end and row end results out.
// ----------------------------------------------------------------------------
// timing: a result is registered in the cycle after the step that makes it;
//   a byte's steps follow its transfer through the sequencer state register
// throughput: a byte takes one step per field end, content byte or pad cell it
//   causes, dropped ones included (a row end takes one per padding cell plus
//   one); steps run at one per cycle while the output slot is free, and so do
//   plain content bytes
// reset: synchronous, clears lexer state, column counter and output valid;
//   column_count returns to 1
`default_nettype none

module csv_record_tokenizer (
   input  logic        clock,
   input  logic        reset,
   crt_req_if.sink     req,
   crt_rsp_if.source   rsp,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import crt_pkg::*;

   logic [COL_W-1:0] column_count_ff, column_count_in;
   logic             csr_write;
   cmd_type          cmd;
   status_type       status;

   // register file: column_count at word 0, upper word ignored
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      column_count_in = column_count_ff;
      if (csr_write && (paddr[2] == REG_COLUMN_COUNT)) begin
         column_count_in = pwdata[COL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= COL_W'(1);
      end else begin
         column_count_ff <= column_count_in;
      end
   end

   // read data is zero outside the register
   assign prdata = (paddr[2] == REG_COLUMN_COUNT) ?
                   {{(32-COL_W){1'b0}}, column_count_ff} : 32'd0;

   // lexer and step sequencer
   crt_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req.valid),
      .req_text_byte  (req.text_byte),
      .req_final_byte (req.final_byte),
      .req_ready      (req.ready),
      .status         (status),
      .cmd            (cmd)
   );

   // column tracking and output register
   crt_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_text_byte (req.text_byte),
      .column_count  (column_count_ff),
      .status        (status),
      .rsp_ready     (rsp.ready),
      .rsp_valid     (rsp.valid),
      .rsp_kind      (rsp.kind),
      .rsp_content   (rsp.content),
      .rsp_column    (rsp.column),
      .rsp_run_last  (rsp.run_last)
   );

   // a row end always closes the run of its byte and sits at column zero
   a_row_end_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.kind == KIND_ROW_END) |-> (rsp.run_last && rsp.column == '0))
      else $error("row end without run_last or with nonzero column");

   // only content results carry a byte
   a_content_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.kind != KIND_CONTENT) |-> (rsp.content == '0))
      else $error("nonzero content on a non-content result");

   // dropped cells never leak out
   a_column_range: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.kind != KIND_ROW_END) |-> (rsp.column < COL_CAP))
      else $error("result column beyond the column cap");

   // no input is taken while a row still has pad steps pending
   a_no_accept_midrow: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_ROW && status.col_lt_n) |-> !req.ready)
      else $error("input accepted during row padding");

endmodule

`default_nettype wire

@@ sim/tb_csv_record_tokenizer.sv @@
// ----------------------------------------------------------------------------
// tb_csv_record_tokenizer
// Self-checking bench for the csv record tokenizer. A directed run of short
// records covers quoting, escapes, line ends, dropped and padded cells and the
// end of input. Random csv rows follow, over several column counts. A
// scoreboard class keeps its own lexer state and predicts the content, field
// end and row end results of every byte transfer.
// ----------------------------------------------------------------------------

module tb_csv_record_tokenizer;
   import crt_pkg::*;

   localparam logic [2:0] COLUMN_COUNT_ADDR = {REG_COLUMN_COUNT, 2'b00};
   localparam int         DRAIN_CYCLES     = 10;
   localparam int         HOLD_CYCLES      = 300;
   localparam int         GAP_PERCENT      = 15;
   localparam int         NUM_PHASES       = 6;
   localparam int         PRESSURE_PHASE   = 3;
   localparam int         MAX_REPORTS      = 10;

   typedef enum logic [1:0] {
      LEX_START,
      LEX_PLAIN,
      LEX_QUOTED,
      LEX_AFTER_QUOTE
   } lex_mode_type;

   // one result of the block
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [BYTE_W-1:0] content;
      logic [COL_W-1:0]  column;
      logic              run_last;
   } token_type;

   // one byte of csv text with its end-of-input flag
   typedef struct packed {
      logic [BYTE_W-1:0] text;
      logic              last;
   } text_item_type;

   // tracks the lexer and holds the tokens still to come
   class scoreboard_type;
      token_type      expected_q[$];
      token_type      run_q[$];
      int             mismatches;
      lex_mode_type   mode;
      bit             cr_pending;
      bit [COL_W-1:0] col;
      bit             row_open;
      bit [COL_W-1:0] col_count;

      function new();
         col_count = COL_W'(1);
         clear_row_state();
      endfunction

      function void clear_row_state();
         mode       = LEX_START;
         cr_pending = 1'b0;
         col        = '0;
         row_open   = 1'b0;
      endfunction

      function void set_columns(input bit [COL_W-1:0] value);
         col_count = value;
      endfunction

      // zero counts as one, and the count never goes past the cap
      function bit [COL_W-1:0] active_columns();
         bit [COL_W-1:0] n;
         n = col_count;
         if (n == 0) n = COL_W'(1);
         if (n > COL_CAP) n = COL_CAP;
         return n;
      endfunction

      function void push_token(input logic [KIND_W-1:0] kind,
                               input logic [BYTE_W-1:0] content,
                               input logic [COL_W-1:0] column);
         token_type t;
         t.kind     = kind;
         t.content  = content;
         t.column   = column;
         t.run_last = 1'b0;
         run_q.push_back(t);
      endfunction

      function void put_content(input logic [BYTE_W-1:0] b);
         if (col < active_columns()) push_token(KIND_CONTENT, b, col);
      endfunction

      function void end_field();
         if (col < active_columns()) push_token(KIND_FIELD_END, '0, col);
         if (col < 63) col++;
      endfunction

      // close the open field, pad the short row, then the row end
      function void end_row();
         bit [COL_W-1:0] n;
         n = active_columns();
         end_field();
         while (col < n) begin
            push_token(KIND_FIELD_END, '0, col);
            col++;
         end
         push_token(KIND_ROW_END, '0, '0);
         col      = '0;
         mode     = LEX_START;
         row_open = 1'b0;
      endfunction

      function void take_byte(input logic [BYTE_W-1:0] b);
         bit brk;
         brk = (b == CHAR_CR) || (b == CHAR_LF);
         // lf right after a cr row end is swallowed
         if (cr_pending) begin
            cr_pending = 1'b0;
            if (b == CHAR_LF) return;
         end
         row_open = 1'b1;
         case (mode)
            LEX_START: begin
               if (b == CHAR_QUOTE) begin
                  mode = LEX_QUOTED;
               end else if (b == CHAR_COMMA) begin
                  end_field();
               end else if (brk) begin
                  end_row();
                  cr_pending = (b == CHAR_CR);
               end else begin
                  put_content(b);
                  mode = LEX_PLAIN;
               end
            end
            LEX_PLAIN: begin
               if (b == CHAR_COMMA) begin
                  end_field();
                  mode = LEX_START;
               end else if (brk) begin
                  end_row();
                  cr_pending = (b == CHAR_CR);
               end else begin
                  put_content(b);
               end
            end
            LEX_QUOTED: begin
               if (b == CHAR_QUOTE) mode = LEX_AFTER_QUOTE;
               else put_content(b);
            end
            default: begin
               if (b == CHAR_QUOTE) begin
                  put_content(b);
                  mode = LEX_QUOTED;
               end else if (b == CHAR_COMMA) begin
                  end_field();
                  mode = LEX_START;
               end else if (brk) begin
                  end_row();
                  cr_pending = (b == CHAR_CR);
               end else begin
                  // stray byte opens a new plain field
                  end_field();
                  put_content(b);
                  mode = LEX_PLAIN;
               end
            end
         endcase
      endfunction

      function void note_input(input logic [BYTE_W-1:0] b, input logic fin);
         token_type t;
         run_q.delete();
         take_byte(b);
         if (fin) begin
            if (row_open) end_row();
            clear_row_state();
         end
         if (run_q.size() > 0) begin
            t = run_q.pop_back();
            t.run_last = 1'b1;
            run_q.push_back(t);
         end
         foreach (run_q[i]) expected_q.push_back(run_q[i]);
      endfunction

      function void report(input string what, input token_type want,
                           input token_type got);
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("%s: expected kind %0d content %02h column %0d last %0d,",
                     what, want.kind, want.content, want.column, want.run_last,
                     " got kind %0d content %02h column %0d last %0d",
                     got.kind, got.content, got.column, got.run_last);
      endfunction

      function void check_result(input token_type got);
         token_type want;
         if (expected_q.size() == 0) begin
            report("result with nothing pending", '0, got);
            return;
         end
         want = expected_q.pop_front();
         if (got.kind !== want.kind || got.content !== want.content ||
             got.column !== want.column || got.run_last !== want.run_last)
            report("result mismatch", want, got);
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   // ------------------------------------------------------------------------
   // clock, reset, channels and the block
   // ------------------------------------------------------------------------
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   crt_req_if req_ch ();
   crt_rsp_if rsp_ch ();

   scoreboard_type sb = new();

   // queue of text bytes built by the row generator, drained by the sender
   text_item_type text_q[$];

   // gap switches for both sides, and the hold-off handshake between the
   // stimulus and the receiver process
   bit req_gaps = 1'b1;
   bit rsp_gaps = 1'b1;
   int hold_asks = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   csv_record_tokenizer dut (
      .clock   (clock),
      .reset   (reset),
      .req     (req_ch),
      .rsp     (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // ------------------------------------------------------------------------
   // monitor: values seen at the edge are the ones the transfer used, since
   // all drivers update through nonblocking assignments
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      token_type got;
      if (!reset) begin
         // input first, a result never leaves in the edge of its own byte
         if (req_ch.valid && req_ch.ready)
            sb.note_input(req_ch.text_byte, req_ch.final_byte);
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.kind     = rsp_ch.kind;
            got.content  = rsp_ch.content;
            got.column   = rsp_ch.column;
            got.run_last = rsp_ch.run_last;
            sb.check_result(got);
         end
      end
   end

   // ------------------------------------------------------------------------
   // receiver: random back-pressure, plus a long hold-off on request so the
   // block fills up and stops taking bytes
   // ------------------------------------------------------------------------
   initial begin : result_sink
      int stall_left;
      int hold_served;
      stall_left  = 0;
      hold_served = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_asks != hold_served) begin
            hold_served++;
            stall_left = HOLD_CYCLES;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= !rsp_gaps || ($urandom_range(99) >= GAP_PERCENT);
         end
      end
   end

   // ------------------------------------------------------------------------
   // drivers
   // ------------------------------------------------------------------------

   // config write: setup cycle, then access cycle until pready
   task automatic csr_write(input logic [2:0] addr, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (addr[2] == REG_COLUMN_COUNT) sb.set_columns(value[COL_W-1:0]);
   endtask

   // offer one byte and hold it until the transfer; valid stays high
   // between back-to-back bytes
   task automatic send_byte(input text_item_type item);
      if (req_gaps && $urandom_range(99) < GAP_PERCENT) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.text_byte  <= item.text;
      req_ch.final_byte <= item.last;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic send_queued(inout int count);
      while (text_q.size() != 0) begin
         send_byte(text_q.pop_front());
         count++;
      end
   endtask

   // wait until every predicted result is in, then let the block settle
   // on bytes that cause no result
   task automatic wait_for_results();
      do @(posedge clock); while (sb.pending() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // csv text generation
   // ------------------------------------------------------------------------
   function automatic void add_text(input logic [BYTE_W-1:0] b, input logic fin = 1'b0);
      text_item_type t;
      t.text = b;
      t.last = fin;
      text_q.push_back(t);
   endfunction

   // unquoted content: separators and line breaks are moved out of the way
   function automatic logic [BYTE_W-1:0] plain_byte();
      logic [BYTE_W-1:0] b;
      b = BYTE_W'($urandom_range(0, 255));
      if (b == CHAR_COMMA || b == CHAR_CR || b == CHAR_LF) b = b ^ 8'h40;
      return b;
   endfunction

   // one csv row with random content; mostly well formed, some noise
   function automatic void gen_row();
      int fields;
      int kind_pick;
      int len;
      int ending;
      int start;
      text_item_type t;
      logic [BYTE_W-1:0] b;
      start = text_q.size();
      if ($urandom_range(9) == 0) fields = $urandom_range(0, sb.active_columns() + 2);
      else fields = $urandom_range(0, 4);
      for (int f = 0; f < fields; f++) begin
         if (f > 0) add_text(CHAR_COMMA);
         kind_pick = $urandom_range(99);
         len = $urandom_range(0, 5);
         if (kind_pick < 50) begin
            for (int i = 0; i < len; i++) add_text(plain_byte());
         end else if (kind_pick < 88) begin
            add_text(CHAR_QUOTE);
            for (int i = 0; i < len; i++) begin
               case ($urandom_range(9))
                  0: b = CHAR_CR;
                  1: b = CHAR_LF;
                  2: b = CHAR_COMMA;
                  3: b = CHAR_QUOTE;
                  default: b = BYTE_W'($urandom_range(0, 255));
               endcase
               // quotes inside a quoted field are escaped by doubling
               if (b == CHAR_QUOTE) add_text(CHAR_QUOTE);
               add_text(b);
            end
            add_text(CHAR_QUOTE);
            // occasional stray byte after the closing quote
            if ($urandom_range(9) == 0) add_text(plain_byte());
         end else begin
            // raw noise, any byte at all
            for (int i = 0; i <= len % 3; i++)
               add_text(BYTE_W'($urandom_range(0, 255)), $urandom_range(49) == 0);
         end
      end
      ending = $urandom_range(99);
      if (ending < 35) begin
         add_text(CHAR_LF, $urandom_range(24) == 0);
      end else if (ending < 60) begin
         add_text(CHAR_CR);
         add_text(CHAR_LF, $urandom_range(24) == 0);
      end else if (ending < 80) begin
         add_text(CHAR_CR, $urandom_range(24) == 0);
      end else if (text_q.size() == start) begin
         add_text(CHAR_LF, 1'b1);
      end else begin
         // input ends inside the row
         t = text_q.pop_back();
         t.last = 1'b1;
         text_q.push_back(t);
      end
   endfunction

   // ------------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------------
   initial begin : stimulus
      int phase_cols [NUM_PHASES];
      int phase_items [NUM_PHASES];
      int sent;

      // every input known from time zero
      req_ch.valid      <= 1'b0;
      req_ch.text_byte  <= '0;
      req_ch.final_byte <= 1'b0;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= '0;
      pwdata  <= '0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed records, three columns
      csr_write(COLUMN_COUNT_ADDR, 32'd3);
      add_text(CHAR_QUOTE);          // quote at field start opens a quoted field
      add_text(8'hFF);
      add_text(CHAR_QUOTE);
      add_text(CHAR_QUOTE);          // doubled quote gives one quote
      add_text(CHAR_CR);             // line break inside quotes is content
      add_text(CHAR_QUOTE);
      add_text("x");                 // stray byte after closing quote
      add_text(CHAR_COMMA);
      add_text(CHAR_COMMA);          // empty field
      add_text(8'h00);               // cell past the column count, dropped
      add_text(CHAR_CR);             // cr row end
      add_text(CHAR_LF);             // lf of crlf, swallowed
      add_text(CHAR_LF);             // empty line, row of empty cells
      add_text("a");
      add_text(CHAR_QUOTE);          // quote inside a plain field is content
      add_text(CHAR_LF);             // short row gets padded
      add_text(CHAR_QUOTE);
      add_text("q", 1'b1);           // unclosed quote at end of input
      add_text("b");
      add_text(CHAR_COMMA, 1'b1);    // trailing empty field at end of input
      add_text(CHAR_CR, 1'b1);       // cr as the last byte
      add_text(CHAR_QUOTE);
      add_text(CHAR_QUOTE);          // quoted empty field
      add_text(CHAR_LF);             // lf right after a closing quote
      add_text(8'h80, 1'b1);         // end of input in a plain field
      sent = 0;
      send_queued(sent);
      req_ch.valid <= 1'b0;
      wait_for_results();

      // random phases; column count extremes, clamped values and a random one
      phase_cols  = '{1, 63, 0, 5, 33, 0};
      phase_cols[NUM_PHASES-1] = $urandom_range(1, 63);
      phase_items = '{50, 60, 30, 80, 40, 70};
      for (int p = 0; p < NUM_PHASES; p++) begin
         csr_write(COLUMN_COUNT_ADDR, phase_cols[p]);
         // pressure phase runs with no gaps on either side, and the receiver
         // holds off long enough for the block to stall its input
         req_gaps = (p != PRESSURE_PHASE);
         rsp_gaps = (p != PRESSURE_PHASE);
         if (p == PRESSURE_PHASE) hold_asks++;
         sent = 0;
         while (sent < phase_items[p]) begin
            gen_row();
            send_queued(sent);
         end
         req_ch.valid <= 1'b0;
         wait_for_results();
      end

      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("csv_record_tokenizer verification clean");
      end else begin
         $display("csv_record_tokenizer verification failed");
      end
      $finish;
   end

   // hard limit on the whole run
   initial begin : watchdog
      #3000000;
      $display("csv_record_tokenizer verification failed");
      $finish;
   end

endmodule
